// ===== rtl/salm_pkg.sv =====
// ----------------------------------------------------------------------------
// salm_pkg
// Shared types and constants of the stream activity and link monitor.
// ----------------------------------------------------------------------------
package salm_pkg;

    localparam int StreamCount  = 3;
    localparam int SourceCount  = StreamCount + 1;
    localparam int TimerW       = 16;
    localparam int CountW       = 32;
    localparam int QueueDepth   = 4;
    localparam int QueuePtrW    = $clog2(QueueDepth);
    localparam int QueueCntW    = $clog2(QueueDepth + 1);
    localparam int SourceIdxW   = $clog2(SourceCount);

    localparam logic [TimerW-1:0] TimeoutReset = 16'd10;

    typedef struct packed {
        logic              fsm_enabled;
        logic [CountW-1:0] video_packet_count;
        logic [CountW-1:0] audio_embedded_packet_count;
        logic [CountW-1:0] audio_board_packet_count;
    } tick_word_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic       last_event;
    } event_word_t;

    // per source: bit 0 link, bits 1..3 video, embedded audio, board audio
    typedef struct packed {
        logic [SourceCount-1:0] hit;
        logic [SourceCount-1:0] off;
    } tick_events_t;

endpackage

// ===== rtl/salm_front.sv =====
// ----------------------------------------------------------------------------
// salm_front
// Accepts ticks, tracks link state and stream timers, classifies events.
// ----------------------------------------------------------------------------
module salm_front
    import salm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         accept,
    input  tick_word_t   tick,
    output logic         q_push,
    output tick_events_t q_data
);

    logic              link_reg;
    logic              link_next;
    logic [TimerW-1:0] timeout_reg;
    logic [CountW-1:0] seen_reg   [StreamCount];
    logic [CountW-1:0] seen_next  [StreamCount];
    logic [TimerW-1:0] timer_reg  [StreamCount];
    logic [TimerW-1:0] timer_next [StreamCount];
    logic [CountW-1:0] cnt        [StreamCount];
    tick_events_t      ev;

    assign cnt[0] = tick.video_packet_count;
    assign cnt[1] = tick.audio_embedded_packet_count;
    assign cnt[2] = tick.audio_board_packet_count;

    always_comb
    begin
        ev.hit[0] = (tick.fsm_enabled != link_reg);
        ev.off[0] = !tick.fsm_enabled;
        link_next = tick.fsm_enabled;
        for (int s = 0; s < StreamCount; s++)
        begin
            if (cnt[s] != seen_reg[s])
            begin
                ev.hit[s+1]   = (timer_reg[s] == '0);
                ev.off[s+1]   = 1'b0;
                timer_next[s] = timeout_reg;
                seen_next[s]  = cnt[s];
            end
            else
            begin
                ev.hit[s+1]   = (timer_reg[s] == TimerW'(1));
                ev.off[s+1]   = 1'b1;
                timer_next[s] = (timer_reg[s] != '0) ? timer_reg[s] - TimerW'(1)
                                                     : timer_reg[s];
                seen_next[s]  = seen_reg[s];
            end
        end
    end

    assign q_push = accept && (|ev.hit);
    assign q_data = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg    <= 1'b0;
            timeout_reg <= TimeoutReset;
            for (int s = 0; s < StreamCount; s++)
            begin
                seen_reg[s]  <= '0;
                timer_reg[s] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            if (accept)
            begin
                link_reg <= link_next;
                for (int s = 0; s < StreamCount; s++)
                begin
                    seen_reg[s]  <= seen_next[s];
                    timer_reg[s] <= timer_next[s];
                end
            end
        end
    end

endmodule

// ===== rtl/salm_queue.sv =====
// ----------------------------------------------------------------------------
// salm_queue
// Short queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module salm_queue
    import salm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tick_events_t push_data,
    output logic         full,
    input  logic         pop,
    output tick_events_t pop_data,
    output logic         empty
);

    tick_events_t         mem [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueueCntW-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == QueueCntW'(QueueDepth));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QueuePtrW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QueuePtrW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QueueCntW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QueueCntW'(1);
            end
        end
    end

endmodule

// ===== rtl/salm_back.sv =====
// ----------------------------------------------------------------------------
// salm_back
// Serializes queued tick events into words, one per cycle while pop keeps the slot free, with last marker.
// ----------------------------------------------------------------------------
module salm_back
    import salm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  tick_events_t q_data,
    output logic         q_pop,
    output logic         empty,
    input  logic         pop,
    output event_word_t  report
);

    logic [SourceCount-1:0] mask_reg;
    logic [SourceCount-1:0] mask_next;
    logic [SourceCount-1:0] off_reg;
    logic [SourceCount-1:0] off_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    event_word_t            out_word_reg;
    event_word_t            out_word_next;
    logic [SourceIdxW-1:0]  idx;
    logic [SourceCount-1:0] pick;
    logic [SourceCount-1:0] mask_after;
    logic                   slot_free;
    logic                   emit;

    always_comb
    begin
        idx = '0;
        for (int i = SourceCount - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = SourceIdxW'(i);
            end
        end
    end

    assign pick       = SourceCount'(1) << idx;
    assign slot_free  = !out_valid_reg || pop;
    assign emit       = slot_free && (|mask_reg);
    assign mask_after = emit ? (mask_reg & ~pick) : mask_reg;
    assign q_pop      = (mask_after == '0) && !q_empty;

    always_comb
    begin
        mask_next      = q_pop ? q_data.hit : mask_after;
        off_next       = q_pop ? q_data.off : off_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_word_next.event_code = {idx, off_reg[idx]};
            out_word_next.last_event = ((mask_reg & ~pick) == '0);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign empty  = !out_valid_reg;
    assign report = out_word_reg;

    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/stream_activity_link_monitor.sv =====
// ----------------------------------------------------------------------------
// stream_activity_link_monitor
// Polls link enable and three packet counters and reports link and stream
// activity changes as a queue of event words.
// ----------------------------------------------------------------------------
// A tick is taken whenever full is low; the front end updates
// link state and stream timers at that edge and drops quiet ticks. Ticks with
// events wait in a four-entry queue, and the back end sends their events in
// the order link, video, embedded audio, board audio at one word per cycle
// while each word is popped, so a tick with n events gives n words. full rises
// only when four eventful ticks are waiting.
module stream_activity_link_monitor
    import salm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  tick_word_t  tick,
    output logic        empty,
    input  logic        pop,
    output event_word_t report
);

    logic         accept;
    logic         q_push;
    tick_events_t q_wdata;
    logic         q_pop;
    tick_events_t q_rdata;
    logic         q_empty;

    assign accept = push && !full;

    salm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .tick      (tick),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    salm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    salm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .report  (report)
    );

endmodule
